@@ rtl/core/drr_pkg.sv @@
// Package: shared types, command codes and power-of-ten table for the rescaler.
`default_nettype none
package drr_pkg;
	localparam int MaxPower = 38;
	localparam int PowW = 6;
	localparam int DataW = 128;
	localparam int CntW = 7;

	localparam logic [2:0] CMD_UP = 3'd0;
	localparam logic [2:0] CMD_HALF = 3'd1;
	localparam logic [2:0] CMD_CEIL = 3'd2;
	localparam logic [2:0] CMD_FLOOR = 3'd3;
	localparam logic [2:0] CMD_TRUNC = 3'd4;

	typedef struct packed {
		logic load;
		logic step_div;
		logic step_mul;
		logic finish;
	} drr_cmd_t;

	typedef struct packed {
		logic pass;
		logic is_up;
		logic done;
	} drr_stat_t;

	// constant table; powers above the maximum map to the maximum
	function automatic logic [DataW-1:0] pow10(input logic [PowW-1:0] p);
		logic [DataW-1:0] r;
		case (p)
			6'd0: r = 128'd1;
			6'd1: r = 128'd10;
			6'd2: r = 128'd100;
			6'd3: r = 128'd1_000;
			6'd4: r = 128'd10_000;
			6'd5: r = 128'd100_000;
			6'd6: r = 128'd1_000_000;
			6'd7: r = 128'd10_000_000;
			6'd8: r = 128'd100_000_000;
			6'd9: r = 128'd1_000_000_000;
			6'd10: r = 128'd10_000_000_000;
			6'd11: r = 128'd100_000_000_000;
			6'd12: r = 128'd1_000_000_000_000;
			6'd13: r = 128'd10_000_000_000_000;
			6'd14: r = 128'd100_000_000_000_000;
			6'd15: r = 128'd1_000_000_000_000_000;
			6'd16: r = 128'd10_000_000_000_000_000;
			6'd17: r = 128'd100_000_000_000_000_000;
			6'd18: r = 128'd1_000_000_000_000_000_000;
			6'd19: r = 128'd10_000_000_000_000_000_000;
			6'd20: r = 128'd100_000_000_000_000_000_000;
			6'd21: r = 128'd1_000_000_000_000_000_000_000;
			6'd22: r = 128'd10_000_000_000_000_000_000_000;
			6'd23: r = 128'd100_000_000_000_000_000_000_000;
			6'd24: r = 128'd1_000_000_000_000_000_000_000_000;
			6'd25: r = 128'd10_000_000_000_000_000_000_000_000;
			6'd26: r = 128'd100_000_000_000_000_000_000_000_000;
			6'd27: r = 128'd1_000_000_000_000_000_000_000_000_000;
			6'd28: r = 128'd10_000_000_000_000_000_000_000_000_000;
			6'd29: r = 128'd100_000_000_000_000_000_000_000_000_000;
			6'd30: r = 128'd1_000_000_000_000_000_000_000_000_000_000;
			6'd31: r = 128'd10_000_000_000_000_000_000_000_000_000_000;
			6'd32: r = 128'd100_000_000_000_000_000_000_000_000_000_000;
			6'd33: r = 128'd1_000_000_000_000_000_000_000_000_000_000_000;
			6'd34: r = 128'd10_000_000_000_000_000_000_000_000_000_000_000;
			6'd35: r = 128'd100_000_000_000_000_000_000_000_000_000_000_000;
			6'd36: r = 128'd1_000_000_000_000_000_000_000_000_000_000_000_000;
			6'd37: r = 128'd10_000_000_000_000_000_000_000_000_000_000_000_000;
			default: r = 128'd100_000_000_000_000_000_000_000_000_000_000_000_000;
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

@@ rtl/core/drr_if.sv @@
// Interfaces: input and output item channels.
`default_nettype none
interface drr_in_if;
	logic valid;
	logic ready;
	logic [2:0] command;
	logic signed [63:0] value_high;
	logic [63:0] value_low;
	logic [5:0] shift_power;
	modport source(output valid, command, value_high, value_low, shift_power, input ready);
	modport sink(input valid, command, value_high, value_low, shift_power, output ready);
endinterface

interface drr_out_if;
	logic valid;
	logic ready;
	logic signed [63:0] result_high;
	logic [63:0] result_low;
	modport source(output valid, result_high, result_low, input ready);
	modport sink(input valid, result_high, result_low, output ready);
endinterface
`default_nettype wire

@@ rtl/core/drr_datapath.sv @@
// Datapath: restoring divider and shift-add multiplier, rounding and sign.
`default_nettype none
module drr_datapath (
	input wire logic clk,
	input wire drr_pkg::drr_cmd_t cmd,
	input wire logic [2:0] command,
	input wire logic [127:0] value,
	input wire logic [5:0] shift_power,
	output drr_pkg::drr_stat_t stat,
	output logic [127:0] result
);
	logic [2:0] cmd_q;
	logic neg_q;
	logic [127:0] n_q, q_q, r_q, d_q;
	logic [5:0] pw_q;
	logic [6:0] cnt_q;
	logic [5:0] p_clamp;
	logic [127:0] mag, r_sh, r_sub, q_fin, half;
	logic ge, inc, rnz;

	assign p_clamp = (shift_power > 6'(drr_pkg::MaxPower)) ? 6'(drr_pkg::MaxPower) : shift_power;
	assign mag = value[127] ? (~value + 128'd1) : value;
	assign r_sh = {r_q[126:0], n_q[127]};
	assign ge = r_sh >= d_q;
	assign r_sub = r_sh - d_q;
	assign half = d_q >> 1;
	assign rnz = r_q != '0;

	always_comb begin
		case (cmd_q)
			drr_pkg::CMD_HALF: inc = r_q >= half;
			drr_pkg::CMD_CEIL: inc = !neg_q && rnz;
			drr_pkg::CMD_FLOOR: inc = neg_q && rnz;
			default: inc = 1'b0;
		endcase
	end
	assign q_fin = q_q + {127'd0, inc};

	assign stat.pass = (p_clamp == '0) || (value == '0) || (command > drr_pkg::CMD_TRUNC);
	assign stat.is_up = command == drr_pkg::CMD_UP;
	assign stat.done = (cmd_q == drr_pkg::CMD_UP) ? (pw_q == '0) : (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= command;
			neg_q <= value[127];
			n_q <= (command == drr_pkg::CMD_UP) ? value : mag;
			d_q <= drr_pkg::pow10(p_clamp);
			pw_q <= p_clamp;
			q_q <= '0;
			r_q <= '0;
			cnt_q <= 7'd127;
			result <= value;
		end else if (cmd.step_mul) begin
			n_q <= (n_q << 3) + (n_q << 1);
			pw_q <= pw_q - 6'd1;
		end else if (cmd.step_div) begin
			n_q <= {n_q[126:0], 1'b0};
			r_q <= ge ? r_sub : r_sh;
			q_q <= {q_q[126:0], ge};
			cnt_q <= cnt_q - 7'd1;
		end else if (cmd.finish) begin
			if (cmd_q == drr_pkg::CMD_UP) begin
				result <= n_q;
			end else begin
				result <= neg_q ? (~q_fin + 128'd1) : q_fin;
			end
		end
	end
endmodule
`default_nettype wire

@@ rtl/core/drr_ctrl.sv @@
// Controller: sequences load, iteration, finish and output handshake.
`default_nettype none
module drr_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input wire logic out_ready,
	input wire drr_pkg::drr_stat_t stat,
	output drr_pkg::drr_cmd_t cmd
);
	typedef enum logic [2:0] {IDLE, MUL, DIV, FIN, OUT} state_t;
	state_t state_q;

	assign in_ready = (state_q == IDLE);
	assign out_valid = (state_q == OUT);

	always_comb begin
		cmd = '0;
		cmd.load = in_valid && in_ready;
		cmd.step_mul = (state_q == MUL) && !stat.done;
		cmd.step_div = (state_q == DIV);
		cmd.finish = (state_q == FIN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
		end else begin
			case (state_q)
				IDLE: if (in_valid) begin
					if (stat.pass) state_q <= OUT;
					else if (stat.is_up) state_q <= MUL;
					else state_q <= DIV;
				end
				MUL: if (stat.done) state_q <= FIN;
				DIV: if (stat.done) state_q <= FIN;
				FIN: state_q <= OUT;
				OUT: if (out_ready) state_q <= IDLE;
				default: state_q <= IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ rtl/core/decimal_rescale_round.sv @@
// Top level: signed 128-bit decimal rescale by a power of ten with rounding.
// channel | dir | payload
// in      | sink   | command, value_high, value_low, shift_power
// out     | source | result_high, result_low
// Scale down: handled by the one-bit-per-cycle restoring divider.
// Scale up: one multiply by ten per cycle.
// Zero value, zero power or unused command: the value passes through unchanged.
// One item at a time; output holds while out.ready is low. Reset clears the controller only.
`default_nettype none
module decimal_rescale_round (
	input wire logic clk,
	input wire logic arst_n,
	drr_in_if.sink in,
	drr_out_if.source out
);
	drr_pkg::drr_cmd_t cmd;
	drr_pkg::drr_stat_t stat;
	logic [127:0] result;

	drr_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in.valid), .in_ready(in.ready),
		.out_valid(out.valid), .out_ready(out.ready),
		.stat(stat), .cmd(cmd)
	);

	drr_datapath u_dp (
		.clk(clk), .cmd(cmd), .command(in.command),
		.value({in.value_high, in.value_low}), .shift_power(in.shift_power),
		.stat(stat), .result(result)
	);

	assign out.result_high = result[127:64];
	assign out.result_low = result[63:0];
endmodule
`default_nettype wire

@@ tb/tb_if.sv @@
// Interfaces: testbench-side channel definitions live in the RTL; this file holds the channel helper package.
`timescale 1ns / 1ps
package tb_drr_pkg;
	typedef struct {
		logic [2:0] command;
		logic [63:0] value_high;
		logic [63:0] value_low;
		logic [5:0] shift_power;
		logic chk;
		logic [127:0] want;
	} stim_row_t;
endpackage

@@ tb/testbench.sv @@
// Testbench: directed table and random items through the decimal rescaler, checked by a predictor.
`timescale 1ns / 1ps
module testbench;
	logic clk;
	logic arst_n;
	drr_in_if in_ch();
	drr_out_if out_ch();

	decimal_rescale_round u_top (.clk(clk), .arst_n(arst_n), .in(in_ch), .out(out_ch));

	logic [127:0] expected_q[$];
	int errors;
	int quiet_cycles;
	int out_count;
	bit stim_done;
	bit no_idle;
	bit hold_off;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [127:0] rescale(logic [2:0] c, logic [127:0] v, logic [5:0] pw);
		int p;
		logic neg;
		logic [127:0] mag;
		logic [127:0] dv;
		logic [127:0] q;
		logic [127:0] rem;
		logic inc;
		p = (pw > drr_pkg::MaxPower) ? drr_pkg::MaxPower : pw;
		if (p == 0 || v == '0 || c > drr_pkg::CMD_TRUNC) return v;
		dv = 128'd1;
		for (int k = 0; k < p; k++) dv = dv * 10;
		if (c == drr_pkg::CMD_UP) return v * dv;
		neg = v[127];
		mag = neg ? -v : v;
		q = mag / dv;
		rem = mag % dv;
		inc = 1'b0;
		case (c)
			drr_pkg::CMD_HALF: inc = rem >= (dv >> 1);
			drr_pkg::CMD_CEIL: inc = !neg && rem != '0;
			drr_pkg::CMD_FLOOR: inc = neg && rem != '0;
			default: inc = 1'b0;
		endcase
		if (inc) q = q + 1;
		return neg ? -q : q;
	endfunction

	task automatic report_mismatch(string what, logic [127:0] got, logic [127:0] want);
		$display("mismatch %s: got %h want %h", what, got, want);
		errors++;
	endtask

	task automatic send_item(tb_drr_pkg::stim_row_t r);
		logic [127:0] w;
		w = rescale(r.command, {r.value_high, r.value_low}, r.shift_power);
		if (r.chk && w != r.want) report_mismatch("predictor vs table", w, r.want);
		while (!no_idle && $urandom_range(99) < 21) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.command <= r.command;
		in_ch.value_high <= r.value_high;
		in_ch.value_low <= r.value_low;
		in_ch.shift_power <= r.shift_power;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		expected_q.push_back(r.chk ? r.want : w);
		@(negedge clk);
	endtask

	function automatic logic [127:0] rand128();
		return {$urandom, $urandom, $urandom, $urandom};
	endfunction

	function automatic tb_drr_pkg::stim_row_t rand_row();
		tb_drr_pkg::stim_row_t r;
		logic [127:0] v;
		int s;
		r.command = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5))
			: 3'($urandom_range(drr_pkg::CMD_TRUNC));
		s = $urandom_range(7);
		case (s)
			0: v = 128'($urandom_range(1000));
			1: v = -128'($urandom_range(1000));
			2: v = {1'b1, 127'b0};
			3: v = rand128() >> $urandom_range(127);
			4: v = -(rand128() >> $urandom_range(127));
			default: v = rand128();
		endcase
		r.value_high = v[127:64];
		r.value_low = v[63:0];
		r.shift_power = ($urandom_range(9) == 0) ? 6'($urandom_range(63))
			: 6'($urandom_range(drr_pkg::MaxPower));
		if (r.command == drr_pkg::CMD_UP && $urandom_range(3) != 0)
			r.shift_power = 6'($urandom_range(6));
		r.chk = 1'b0;
		r.want = '0;
		return r;
	endfunction

	tb_drr_pkg::stim_row_t directed[] = '{
		'{drr_pkg::CMD_UP, 64'd0, 64'd0, 6'd38, 1'b1, 128'd0},
		'{drr_pkg::CMD_UP, 64'd0, 64'd7, 6'd0, 1'b1, 128'd7},
		'{drr_pkg::CMD_UP, 64'd0, 64'd1, 6'd1, 1'b1, 128'd10},
		'{drr_pkg::CMD_UP, 64'd0, 64'd1, 6'd38, 1'b0, 128'd0},
		'{drr_pkg::CMD_UP, 64'd0, 64'd1, 6'd63, 1'b0, 128'd0},
		'{drr_pkg::CMD_UP, '1, '1, 6'd2, 1'b1, -128'd100},
		'{drr_pkg::CMD_HALF, 64'd0, 64'd15, 6'd1, 1'b1, 128'd2},
		'{drr_pkg::CMD_HALF, '1, -64'd15, 6'd1, 1'b1, -128'd2},
		'{drr_pkg::CMD_HALF, 64'd0, 64'd14, 6'd1, 1'b1, 128'd1},
		'{drr_pkg::CMD_CEIL, 64'd0, 64'd11, 6'd1, 1'b1, 128'd2},
		'{drr_pkg::CMD_CEIL, '1, -64'd11, 6'd1, 1'b1, -128'd1},
		'{drr_pkg::CMD_FLOOR, 64'd0, 64'd11, 6'd1, 1'b1, 128'd1},
		'{drr_pkg::CMD_FLOOR, '1, -64'd11, 6'd1, 1'b1, -128'd2},
		'{drr_pkg::CMD_TRUNC, '1, -64'd19, 6'd1, 1'b1, -128'd1},
		'{drr_pkg::CMD_TRUNC, 64'h8000000000000000, 64'd0, 6'd38, 1'b0, 128'd0},
		'{drr_pkg::CMD_FLOOR, 64'h8000000000000000, 64'd0, 6'd63, 1'b0, 128'd0},
		'{drr_pkg::CMD_HALF, 64'h7fffffffffffffff, '1, 6'd38, 1'b0, 128'd0},
		'{drr_pkg::CMD_CEIL, 64'h7fffffffffffffff, '1, 6'd50, 1'b0, 128'd0},
		'{3'd5, 64'd3, 64'd4, 6'd5, 1'b1, {64'd3, 64'd4}},
		'{3'd6, '1, '1, 6'd9, 1'b1, '1},
		'{3'd7, 64'd1, 64'd0, 6'd38, 1'b1, {64'd1, 64'd0}},
		'{drr_pkg::CMD_TRUNC, 64'd0, 64'd0, 6'd10, 1'b1, 128'd0},
		'{drr_pkg::CMD_HALF, 64'd5, 64'd9, 6'd0, 1'b1, {64'd5, 64'd9}}
	};

	initial begin
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.command = '0;
		in_ch.value_high = '0;
		in_ch.value_low = '0;
		in_ch.shift_power = '0;
		errors = 0;
		stim_done = 1'b0;
		no_idle = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		foreach (directed[i]) send_item(directed[i]);
		for (int n = 0; n < 1050; n++) begin
			no_idle = (n >= 400 && n < 550);
			send_item(rand_row());
		end
		in_ch.valid <= 1'b0;
		stim_done = 1'b1;
	end

	initial begin
		out_ch.ready = 1'b0;
		hold_off = 1'b0;
		out_count = 0;
		forever begin
			@(negedge clk);
			if (!hold_off && out_count >= 300) begin
				hold_off = 1'b1;
				out_ch.ready <= 1'b0;
				repeat (600) @(negedge clk);
			end
			out_ch.ready <= no_idle || $urandom_range(99) >= 21;
		end
	end

	always @(posedge clk) begin
		if (out_ch.valid && out_ch.ready) begin
			out_count++;
			if (expected_q.size() == 0) begin
				report_mismatch("unexpected item", {out_ch.result_high, out_ch.result_low}, '0);
			end else begin
				logic [127:0] w;
				w = expected_q.pop_front();
				if (out_ch.result_high !== w[127:64])
					report_mismatch("result_high", {out_ch.result_high, 64'd0}, {w[127:64], 64'd0});
				if (out_ch.result_low !== w[63:0])
					report_mismatch("result_low", {64'd0, out_ch.result_low}, {64'd0, w[63:0]});
			end
		end
	end

	initial begin
		quiet_cycles = 0;
		forever begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles > 5000) begin
				$display("testbench: done, errors");
				$finish;
			end
		end
	end

	initial begin
		wait (stim_done);
		while (expected_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end
endmodule
